// ===== hw/rtl/bbfc_pkg.sv =====
package bbfc_pkg;

	localparam int IndexW = 7;
	localparam int OrderW = 3;
	localparam int SpaceOrder = 7;

	typedef logic [IndexW-1:0] idx_t;
	typedef logic [OrderW-1:0] ord_t;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_DOUBLE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch aligned, saturated request
		logic rd_buddy;  // read the buddy's mark instead of the block's own
		logic merge;     // clear buddy mark, keep lower index, raise order
		logic set_mark;  // mark the current block free
		logic emit;      // load the result register
		logic dbl;       // result is a double free
	} bbfc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic marked;    // selected mark is set
		logic at_top;    // current order is the top order
		logic can_emit;  // result register free or being drained
	} bbfc_sts_t;

endpackage

// ===== hw/rtl/bbfc_in_if.sv =====
interface bbfc_in_if;
	logic valid;
	logic ready;
	bbfc_pkg::idx_t block_index;
	bbfc_pkg::ord_t block_order;

	modport source(output valid, output block_index, output block_order, input ready);
	modport sink(input valid, input block_index, input block_order, output ready);
endinterface

// ===== hw/rtl/bbfc_out_if.sv =====
interface bbfc_out_if;
	logic valid;
	logic ready;
	bbfc_pkg::idx_t merged_index;
	bbfc_pkg::ord_t merged_order;
	logic status;

	modport source(output valid, output merged_index, output merged_order, output status,
		input ready);
	modport sink(input valid, input merged_index, input merged_order, input status,
		output ready);
endinterface

// ===== hw/rtl/bbfc_ctrl.sv =====
module bbfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bbfc_pkg::bbfc_sts_t sts,
	output bbfc_pkg::bbfc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_CLIMB = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.marked) begin
					// double free: report, touch no mark
					if (sts.can_emit) begin
						cmd.emit = 1'b1;
						cmd.dbl = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_CLIMB;
				end
			end
			ST_CLIMB: begin
				cmd.rd_buddy = 1'b1;
				if (!sts.at_top && sts.marked) begin
					cmd.merge = 1'b1;
				end else if (sts.can_emit) begin
					cmd.set_mark = 1'b1;
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");

	a_no_merge_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> !sts.at_top)
		else $error("merge at top order");

	a_emit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE)
		else $error("emit did not return to idle");

endmodule

// ===== hw/rtl/bbfc_dpath.sv =====
module bbfc_dpath #(
	parameter int NUM_ORDERS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bbfc_pkg::bbfc_cmd_t cmd,
	output bbfc_pkg::bbfc_sts_t sts,
	input  bbfc_pkg::idx_t      in_index,
	input  bbfc_pkg::ord_t      in_order,
	input  logic                out_ready,
	output logic                out_valid,
	output bbfc_pkg::idx_t      out_index,
	output bbfc_pkg::ord_t      out_order,
	output logic                out_status
);

	localparam int TopInt = (NUM_ORDERS - 1 < bbfc_pkg::SpaceOrder) ?
		(NUM_ORDERS - 1) : bbfc_pkg::SpaceOrder;
	localparam int Rows = TopInt + 1;
	localparam int RowW = $clog2(Rows);
	localparam int Bits = 1 << bbfc_pkg::IndexW;
	localparam bbfc_pkg::ord_t TopOrd = bbfc_pkg::OrderW'(TopInt);

	logic [Bits-1:0] marks_q [Rows];
	bbfc_pkg::idx_t idx_q;
	bbfc_pkg::ord_t ord_q;
	bbfc_pkg::idx_t out_index_q;
	bbfc_pkg::ord_t out_order_q;
	logic out_status_q;
	logic out_valid_q;

	bbfc_pkg::ord_t sat_ord;
	bbfc_pkg::idx_t aligned_idx;
	bbfc_pkg::idx_t ord_bit;
	bbfc_pkg::idx_t buddy;
	bbfc_pkg::idx_t rd_idx;
	logic [RowW-1:0] row;

	// saturate order, drop index bits below the block's alignment
	assign sat_ord = (in_order > TopOrd) ? TopOrd : in_order;
	assign aligned_idx = in_index & (bbfc_pkg::idx_t'('1) << sat_ord);

	assign ord_bit = bbfc_pkg::idx_t'(1) << ord_q;
	assign buddy = idx_q ^ ord_bit;
	assign rd_idx = cmd.rd_buddy ? buddy : idx_q;
	assign row = ord_q[RowW-1:0];

	assign sts.marked = marks_q[row][rd_idx];
	assign sts.at_top = (ord_q == TopOrd);
	assign sts.can_emit = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= aligned_idx;
			ord_q <= sat_ord;
		end else if (cmd.merge) begin
			idx_q <= idx_q & ~ord_bit;
			ord_q <= ord_q + bbfc_pkg::ord_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < Rows; r++) begin
				marks_q[r] <= '0;
			end
		end else if (cmd.merge) begin
			marks_q[row][buddy] <= 1'b0;
		end else if (cmd.set_mark) begin
			marks_q[row][idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= idx_q;
			out_order_q <= ord_q;
			out_status_q <= cmd.dbl ? bbfc_pkg::STATUS_DOUBLE : bbfc_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_order = out_order_q;
	assign out_status = out_status_q;

	a_merge_climbs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |=> ord_q == $past(ord_q) + bbfc_pkg::ord_t'(1))
		else $error("merge did not raise order");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q || out_ready)
		else $error("result overwritten before taken");

	a_merge_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |=> !marks_q[$past(row)][$past(buddy)])
		else $error("buddy mark not cleared");

endmodule

// ===== hw/rtl/buddy_block_free_coalesce.sv =====
// Channel    Dir  Payload                                   Meaning
// free_req   in   block_index[6:0], block_order[2:0]        block to release
// free_rsp   out  merged_index[6:0], merged_order[2:0],     resulting free block,
//                 status                                    status 1 = double free
//
// One transaction at a time: accept, check the block's own mark, then one merge
// step per free buddy and a final step that sets the mark and emits; at most
// min(NUM_ORDERS-1, 7) merges per free (7 at the default).
// A double free ends at the check.
// Reset clears every free mark at once: nothing is free after reset.
// A held result does not block the next accept; a new result waits in the check
// or the final step while the previous one is still not taken.
module buddy_block_free_coalesce #(
	parameter int NUM_ORDERS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	bbfc_in_if.sink           free_req,
	bbfc_out_if.source        free_rsp
);

	bbfc_pkg::bbfc_cmd_t cmd;
	bbfc_pkg::bbfc_sts_t sts;

	// sequencer: idle, check own mark, climb through buddies
	bbfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (free_req.valid),
		.in_ready (free_req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// free bitmaps, working block register and result register
	bbfc_dpath #(
		.NUM_ORDERS (NUM_ORDERS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_index   (free_req.block_index),
		.in_order   (free_req.block_order),
		.out_ready  (free_rsp.ready),
		.out_valid  (free_rsp.valid),
		.out_index  (free_rsp.merged_index),
		.out_order  (free_rsp.merged_order),
		.out_status (free_rsp.status)
	);

endmodule

// ===== bench/buddy_block_free_coalesce_tb.sv =====
module buddy_block_free_coalesce_tb;

	localparam int NUM_ORDERS = 8;
	// merging stops at the lower of the last size class and the whole space
	localparam int TopOrder = (NUM_ORDERS - 1 < bbfc_pkg::SpaceOrder) ?
		NUM_ORDERS - 1 : bbfc_pkg::SpaceOrder;
	localparam int SpaceBlocks = 1 << bbfc_pkg::IndexW;
	localparam int RandomFrees = 1310;
	localparam int MaxReports = 10;
	// receiver hold-off long enough that the block must stall its input
	localparam int HoldOffCycles = 300;
	// settle time after the last result; allow generous slack
	localparam int DrainCycles = 40;
	// longest quiet stretch of a correct run is the hold-off plus a long gap
	localparam int WatchdogLimit = 2000;

	typedef struct packed {
		bbfc_pkg::idx_t merged_index;
		bbfc_pkg::ord_t merged_order;
		logic status;
	} free_result_t;

	logic clk;
	logic arst_n;

	bbfc_in_if free_req();
	bbfc_out_if free_rsp();

	buddy_block_free_coalesce #(
		.NUM_ORDERS(NUM_ORDERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.free_req(free_req),
		.free_rsp(free_rsp)
	);

	// Model copy of the per-order free bitmaps: bit i of row k set means the
	// order-k block starting at index i is free.
	logic [SpaceBlocks-1:0] free_map [bbfc_pkg::SpaceOrder+1];
	free_result_t pending_results[$];

	int error_count = 0;
	int frees_sent = 0;
	int merge_steps = 0;
	int top_reached = 0;
	int double_frees = 0;
	int results_seen = 0;
	bit hold_off_req = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Count a failure; print only the first few so the log stays readable.
	function automatic void flag_error(string what);
		error_count++;
		if (error_count <= MaxReports)
			$display("ERROR: %s", what);
	endfunction

	// Random gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Apply one free to the model bitmaps and return the result the block
	// should produce for it.
	function automatic free_result_t coalesce_free(bbfc_pkg::idx_t blk_idx,
		bbfc_pkg::ord_t blk_ord);
		int unsigned ord;
		int unsigned idx;
		int unsigned buddy;
		bit merging;
		free_result_t res;
		ord = blk_ord;
		idx = blk_idx;
		// saturate an order past the last size class
		if (ord > NUM_ORDERS - 1)
			ord = NUM_ORDERS - 1;
		// drop index bits below the block's alignment
		idx = idx & ~((1 << ord) - 1) & (SpaceBlocks - 1);
		if (free_map[ord][idx]) begin
			double_frees++;
			res.merged_index = bbfc_pkg::idx_t'(idx);
			res.merged_order = bbfc_pkg::ord_t'(ord);
			res.status = bbfc_pkg::STATUS_DOUBLE;
			return res;
		end
		merging = 1'b1;
		while (merging && ord < TopOrder) begin
			buddy = (idx ^ (1 << ord)) & (SpaceBlocks - 1);
			if (!free_map[ord][buddy]) begin
				merging = 1'b0;
			end else begin
				// absorb the buddy: clear its mark, keep the lower start, climb
				free_map[ord][buddy] = 1'b0;
				if (buddy < idx)
					idx = buddy;
				ord++;
				merge_steps++;
			end
		end
		if (ord == TopOrder)
			top_reached++;
		free_map[ord][idx] = 1'b1;
		res.merged_index = bbfc_pkg::idx_t'(idx);
		res.merged_order = bbfc_pkg::ord_t'(ord);
		res.status = bbfc_pkg::STATUS_OK;
		return res;
	endfunction

	// Offer one free request and hold it until the block takes it. Called and
	// returning in the time step of a rising edge; the request stays valid on
	// return so a back-to-back item follows without a gap.
	task automatic send_free(input bbfc_pkg::idx_t blk_idx, input bbfc_pkg::ord_t blk_ord,
		input bit paced);
		int gap;
		gap = paced ? pick_gap() : 0;
		if (gap != 0) begin
			free_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		free_req.valid <= 1'b1;
		free_req.block_index <= blk_idx;
		free_req.block_order <= blk_ord;
		// sample ready at the falling edge, where nothing is changing
		forever begin
			@(negedge clk);
			if (free_req.ready)
				break;
		end
		@(posedge clk);
		pending_results.push_back(coalesce_free(blk_idx, blk_ord));
		frees_sent++;
	endtask

	// Empty bitmaps after reset: free, double free, then pair up buddies.
	task automatic test_first_frees();
		send_free(7'd0, 3'd0, 1'b1);
		send_free(7'd0, 3'd0, 1'b1);
		send_free(7'd1, 3'd0, 1'b1);
		send_free(7'd3, 3'd0, 1'b1);
		send_free(7'd2, 3'd0, 1'b1);
		send_free(7'd2, 3'd1, 1'b1);
	endtask

	// Misaligned starts: the low index bits must be ignored, for the mark check too.
	task automatic test_misaligned();
		send_free(7'd127, 3'd3, 1'b1);
		send_free(7'd121, 3'd3, 1'b1);
		send_free(7'h55, 3'd2, 1'b1);
		send_free(7'd127, 3'd0, 1'b1);
		send_free(7'd126, 3'd0, 1'b0);
	endtask

	// One block per order, each the buddy of what is already free, so that the
	// last free climbs all the way to the top order; then hit the top twice.
	task automatic test_full_climb();
		send_free(7'd4, 3'd2, 1'b1);
		send_free(7'd8, 3'd3, 1'b1);
		send_free(7'd16, 3'd4, 1'b1);
		send_free(7'd32, 3'd5, 1'b1);
		send_free(7'd64, 3'd6, 1'b1);
		send_free(7'd127, 3'd7, 1'b1);
		send_free(7'd0, 3'd7, 1'b0);
		send_free(7'd64, 3'd6, 1'b1);
		send_free(7'd0, 3'd6, 1'b1);
	endtask

	// Hold the receiver off while requests keep coming back to back.
	task automatic test_backpressure();
		int k;
		hold_off_req = 1'b1;
		for (k = 0; k < 16; k++)
			send_free(bbfc_pkg::idx_t'($urandom_range(0, SpaceBlocks - 1)),
				bbfc_pkg::ord_t'($urandom_range(0, 7)), 1'b0);
	endtask

	// Mostly buddy frees that coalesce, some repeats of free blocks, some noise.
	task automatic test_random_frees(input int count);
		int k;
		int probe;
		int unsigned r;
		int unsigned ord;
		int unsigned idx;
		int unsigned low_bits;
		bit paced;
		bit found;
		for (k = 0; k < count; k++) begin
			// every fourth run of 40 goes without sender gaps
			paced = ((k / 40) % 4) != 3;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				ord = $urandom_range(0, TopOrder - 1);
				idx = $urandom_range(0, SpaceBlocks - 1) & ~((1 << ord) - 1);
				low_bits = ($urandom_range(0, 3) == 0) ? ($urandom & ((1 << ord) - 1)) : 0;
				// free the buddy of a free block to force a merge
				if (free_map[ord][idx])
					idx = idx ^ (1 << ord);
				send_free(bbfc_pkg::idx_t'(idx | low_bits), bbfc_pkg::ord_t'(ord), paced);
			end else if (r < 75) begin
				found = 1'b0;
				ord = 0;
				idx = 0;
				for (probe = 0; probe < 16 && !found; probe++) begin
					ord = $urandom_range(0, NUM_ORDERS - 1);
					idx = $urandom_range(0, SpaceBlocks - 1) & ~((1 << ord) - 1);
					found = free_map[ord][idx];
				end
				low_bits = $urandom & ((1 << ord) - 1);
				send_free(bbfc_pkg::idx_t'(idx | low_bits), bbfc_pkg::ord_t'(ord), paced);
			end else begin
				send_free(bbfc_pkg::idx_t'($urandom_range(0, SpaceBlocks - 1)),
					bbfc_pkg::ord_t'($urandom_range(0, 7)), paced);
			end
		end
	endtask

	// Receiver pacing: runs of ready broken by random gaps, plus the long
	// hold-off when a test asks for one.
	initial begin : rsp_pacer
		int run;
		int gap;
		free_rsp.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				free_rsp.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				free_rsp.ready <= 1'b1;
				run = $urandom_range(1, 24);
				repeat (run) @(posedge clk);
				gap = pick_gap();
				if (gap != 0) begin
					free_rsp.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Check each result transaction against the oldest pending prediction.
	// Sample at the falling edge; the transaction completes at the next rise.
	always @(negedge clk) begin : rsp_check
		free_result_t want;
		free_result_t got;
		if (arst_n && free_rsp.valid && free_rsp.ready) begin
			got.merged_index = free_rsp.merged_index;
			got.merged_order = free_rsp.merged_order;
			got.status = free_rsp.status;
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result: index %0d order %0d status %0d",
					got.merged_index, got.merged_order, got.status));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_error($sformatf(
						"result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d (idx/ord/st)",
						results_seen, want.merged_index, want.merged_order, want.status,
						got.merged_index, got.merged_order, got.status));
			end
		end
	end

	// Stop the run if no transaction moves on either side for too long.
	always @(negedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((free_req.valid && free_req.ready) ||
			(free_rsp.valid && free_rsp.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WatchdogLimit) begin
				$display("timeout: no transaction for %0d cycles, %0d results pending",
					quiet, pending_results.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : main
		int k;
		for (k = 0; k <= bbfc_pkg::SpaceOrder; k++)
			free_map[k] = '0;
		free_req.valid <= 1'b0;
		free_req.block_index <= '0;
		free_req.block_order <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_frees();
		test_misaligned();
		test_full_climb();
		test_backpressure();
		test_random_frees(RandomFrees);

		// drop the request and let every outstanding result drain
		free_req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Ran %0d frees: %0d coalescing steps, %0d ended at the top order,",
			frees_sent, merge_steps, top_reached);
		$display("%0d double frees; checked %0d results with a %0d-cycle hold-off, %0d errors.",
			double_frees, results_seen, HoldOffCycles, error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bbfc_pkg.sv
hw/rtl/bbfc_in_if.sv
hw/rtl/bbfc_out_if.sv
hw/rtl/bbfc_ctrl.sv
hw/rtl/bbfc_dpath.sv
hw/rtl/buddy_block_free_coalesce.sv
bench/buddy_block_free_coalesce_tb.sv
